// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands shared by the rtl, clocked on clk, held off in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// when cond holds, expr must hold on the following clock edge
`define ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// File: rtl/lcfb_pkg.sv
// ----------------------------------------------------------------------------
// lcfb_pkg
// shared types, constants and helpers of the lighting command frame builder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lcfb_pkg;

    localparam int MAX_CHANNELS = 16;

    // queue depths between front and back and on the result side
    localparam int JOB_DEPTH  = 2;
    localparam int BYTE_DEPTH = 4;

    // input mode codes
    localparam logic [1:0] MODE_SINGLE = 2'd0;
    localparam logic [1:0] MODE_MULTI  = 2'd1;
    localparam logic [1:0] MODE_STATUS = 2'd2;
    localparam logic [1:0] MODE_RESET  = 2'd3;

    // header byte values
    localparam logic [7:0] HDR_STATUS_OK = 8'h01;
    localparam logic [7:0] PT_REQUEST    = 8'h00;
    localparam logic [7:0] PT_TRANSMIT   = 8'h02;
    localparam logic [7:0] CMD_SET_ONE   = 8'h01;
    localparam logic [7:0] CMD_SET_ALL   = 8'h02;
    localparam logic [7:0] CMD_STATUS    = 8'h03;
    localparam logic [7:0] CMD_ERR_RESET = 8'h04;
    localparam logic [7:0] LEN_SHORT     = 8'h08;
    localparam logic [7:0] LEN_SINGLE    = 8'h0B;
    localparam logic [7:0] BYTE_ZERO     = 8'h00;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // byte slots of one frame piece, in send order
    localparam int NUM_SLOTS = 11;
    localparam logic [3:0] SLOT_TERM  = 4'd0;
    localparam logic [3:0] SLOT_PTYPE = 4'd1;
    localparam logic [3:0] SLOT_CMD   = 4'd2;
    localparam logic [3:0] SLOT_STAT  = 4'd3;
    localparam logic [3:0] SLOT_LENH  = 4'd4;
    localparam logic [3:0] SLOT_LENL  = 4'd5;
    localparam logic [3:0] SLOT_CHAN  = 4'd6;
    localparam logic [3:0] SLOT_DUTYH = 4'd7;
    localparam logic [3:0] SLOT_DUTYL = 4'd8;
    localparam logic [3:0] SLOT_CRCL  = 4'd9;
    localparam logic [3:0] SLOT_CRCH  = 4'd10;

    localparam logic [NUM_SLOTS-1:0] MASK_HEADER = 11'b000_0011_1111;
    localparam logic [NUM_SLOTS-1:0] MASK_CHAN   = 11'b000_0100_0000;
    localparam logic [NUM_SLOTS-1:0] MASK_DUTY   = 11'b001_1000_0000;
    localparam logic [NUM_SLOTS-1:0] MASK_CRC    = 11'b110_0000_0000;

    // one classified piece of work handed from front to back
    typedef struct packed {
        logic [NUM_SLOTS-1:0] mask;
        logic [7:0]           terminal;
        logic [7:0]           ptype;
        logic [7:0]           cmd;
        logic [7:0]           len;
        logic [7:0]           channel;
        logic [15:0]          duty;
    } job_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // frame size as used: zero acts as one, capped at the channel maximum
    function automatic logic [4:0] clamp_channels(input logic [4:0] n);
        logic [4:0] r;
        if (n == 5'd0)
        begin
            r = 5'd1;
        end
        else if (n > 5'(MAX_CHANNELS))
        begin
            r = 5'(MAX_CHANNELS);
        end
        else
        begin
            r = n;
        end
        return r;
    endfunction

endpackage

// File: rtl/lcfb_front.sv
// ----------------------------------------------------------------------------
// lcfb_front
// takes input words, tracks the open multi-channel frame and queues jobs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcfb_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [1:0]           mode,
    input  logic [7:0]           terminal,
    input  logic [7:0]           channel,
    input  logic [15:0]          duty,
    input  logic [4:0]           frame_channels,
    input  logic [4:0]           active_channels,
    output logic                 job_valid,
    output lcfb_pkg::job_t       job,
    input  logic                 job_take
);

    lcfb_pkg::job_t q_reg [lcfb_pkg::JOB_DEPTH];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic [4:0]     element_index_reg, element_index_next;

    lcfb_pkg::job_t new_job;
    logic [4:0]     nch;
    logic [5:0]     pos_inc;
    logic           closes;
    logic           accept;

    assign accept = push && !full;
    assign full   = (cnt_reg == 2'(lcfb_pkg::JOB_DEPTH));

    assign nch     = lcfb_pkg::clamp_channels(frame_channels);
    assign pos_inc = {1'b0, element_index_reg} + 6'd1;
    assign closes  = (pos_inc >= {1'b0, nch});

    always_comb
    begin
        new_job.terminal = terminal;
        new_job.channel  = channel;
        new_job.duty     = duty;
        new_job.len      = lcfb_pkg::LEN_SHORT;
        new_job.ptype    = lcfb_pkg::PT_TRANSMIT;
        new_job.cmd      = lcfb_pkg::CMD_ERR_RESET;
        new_job.mask     = lcfb_pkg::MASK_HEADER | lcfb_pkg::MASK_CRC;
        element_index_next = 5'd0;
        unique case (mode)
            lcfb_pkg::MODE_SINGLE:
            begin
                new_job.cmd  = lcfb_pkg::CMD_SET_ONE;
                new_job.len  = lcfb_pkg::LEN_SINGLE;
                new_job.mask = lcfb_pkg::MASK_HEADER | lcfb_pkg::MASK_CHAN
                             | lcfb_pkg::MASK_DUTY | lcfb_pkg::MASK_CRC;
            end
            lcfb_pkg::MODE_MULTI:
            begin
                new_job.cmd  = lcfb_pkg::CMD_SET_ALL;
                new_job.len  = lcfb_pkg::LEN_SHORT + {2'b00, nch, 1'b0};
                new_job.mask = lcfb_pkg::MASK_DUTY;
                if (element_index_reg == 5'd0)
                begin
                    new_job.mask = new_job.mask | lcfb_pkg::MASK_HEADER;
                end
                if (closes)
                begin
                    new_job.mask = new_job.mask | lcfb_pkg::MASK_CRC;
                end
                else
                begin
                    element_index_next = pos_inc[4:0];
                end
                // positions past the active count go out as zero
                if (element_index_reg >= active_channels)
                begin
                    new_job.duty = 16'h0000;
                end
            end
            lcfb_pkg::MODE_STATUS:
            begin
                new_job.ptype = lcfb_pkg::PT_REQUEST;
                new_job.cmd   = lcfb_pkg::CMD_STATUS;
            end
            default:
            begin
                new_job.cmd = lcfb_pkg::CMD_ERR_RESET;
            end
        endcase
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (accept)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (job_take)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (accept && !job_take)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!accept && job_take)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg        <= 1'b0;
            rd_ptr_reg        <= 1'b0;
            cnt_reg           <= 2'd0;
            element_index_reg <= 5'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
            if (accept)
            begin
                element_index_reg <= element_index_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg[wr_ptr_reg] <= new_job;
        end
    end

    assign job_valid = (cnt_reg != 2'd0);
    assign job       = q_reg[rd_ptr_reg];

endmodule

// File: rtl/lcfb_back.sv
// ----------------------------------------------------------------------------
// lcfb_back
// walks jobs by slot, a byte a cycle when not full, keeps crc, queues bytes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcfb_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 job_valid,
    input  lcfb_pkg::job_t       job,
    output logic                 job_take,
    output logic                 empty,
    input  logic                 pop,
    output logic [7:0]           out_byte,
    output logic                 frame_end
);

    lcfb_pkg::job_t cur_reg, cur_next;
    logic [15:0]    crc_reg, crc_next;

    logic [7:0] ob_reg [lcfb_pkg::BYTE_DEPTH];
    logic       fe_reg [lcfb_pkg::BYTE_DEPTH];
    logic [1:0] owr_ptr_reg, ord_ptr_reg;
    logic [2:0] ocnt_reg, ocnt_next;

    logic                          ofull;
    logic                          emit;
    logic                          last;
    logic                          take_out;
    logic [3:0]                    slot;
    logic [7:0]                    byte_val;
    logic                          is_end;
    logic [lcfb_pkg::NUM_SLOTS-1:0] rest;

    assign ofull    = (ocnt_reg == 3'(lcfb_pkg::BYTE_DEPTH));
    assign emit     = (cur_reg.mask != '0) && !ofull;
    assign rest     = cur_reg.mask & (cur_reg.mask - 1'b1);
    assign last     = (rest == '0);
    // next job loads as the last byte of this one leaves, so no bubble
    assign job_take = job_valid && ((cur_reg.mask == '0) || (emit && last));
    assign take_out = pop && !empty;

    always_comb
    begin
        slot = 4'd0;
        for (int i = lcfb_pkg::NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (cur_reg.mask[i])
            begin
                slot = 4'(i);
            end
        end
    end

    always_comb
    begin
        is_end = 1'b0;
        case (slot)
            lcfb_pkg::SLOT_TERM:  byte_val = cur_reg.terminal;
            lcfb_pkg::SLOT_PTYPE: byte_val = cur_reg.ptype;
            lcfb_pkg::SLOT_CMD:   byte_val = cur_reg.cmd;
            lcfb_pkg::SLOT_STAT:  byte_val = lcfb_pkg::HDR_STATUS_OK;
            lcfb_pkg::SLOT_LENH:  byte_val = lcfb_pkg::BYTE_ZERO;
            lcfb_pkg::SLOT_LENL:  byte_val = cur_reg.len;
            lcfb_pkg::SLOT_CHAN:  byte_val = cur_reg.channel;
            lcfb_pkg::SLOT_DUTYH: byte_val = cur_reg.duty[15:8];
            lcfb_pkg::SLOT_DUTYL: byte_val = cur_reg.duty[7:0];
            lcfb_pkg::SLOT_CRCL:  byte_val = crc_reg[7:0];
            lcfb_pkg::SLOT_CRCH:
            begin
                byte_val = crc_reg[15:8];
                is_end   = 1'b1;
            end
            default:              byte_val = lcfb_pkg::BYTE_ZERO;
        endcase
    end

    always_comb
    begin
        crc_next = crc_reg;
        if (emit)
        begin
            if (slot == lcfb_pkg::SLOT_CRCH)
            begin
                crc_next = lcfb_pkg::CRC_INIT;
            end
            else if (slot != lcfb_pkg::SLOT_CRCL)
            begin
                // a header always opens a fresh crc
                crc_next = lcfb_pkg::crc_byte(
                    (slot == lcfb_pkg::SLOT_TERM) ? lcfb_pkg::CRC_INIT : crc_reg,
                    byte_val);
            end
        end
    end

    always_comb
    begin
        cur_next = cur_reg;
        if (job_take)
        begin
            cur_next = job;
        end
        else if (emit)
        begin
            cur_next.mask = rest;
        end
    end

    always_comb
    begin
        ocnt_next = ocnt_reg;
        if (emit && !take_out)
        begin
            ocnt_next = ocnt_reg + 3'd1;
        end
        else if (!emit && take_out)
        begin
            ocnt_next = ocnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg      <= '0;
            crc_reg      <= lcfb_pkg::CRC_INIT;
            owr_ptr_reg  <= 2'd0;
            ord_ptr_reg  <= 2'd0;
            ocnt_reg     <= 3'd0;
        end
        else
        begin
            cur_reg      <= cur_next;
            crc_reg      <= crc_next;
            ocnt_reg     <= ocnt_next;
            if (emit)
            begin
                owr_ptr_reg <= owr_ptr_reg + 2'd1;
            end
            if (take_out)
            begin
                ord_ptr_reg <= ord_ptr_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            ob_reg[owr_ptr_reg] <= byte_val;
            fe_reg[owr_ptr_reg] <= is_end;
        end
    end

    assign empty     = (ocnt_reg == 3'd0);
    assign out_byte  = ob_reg[ord_ptr_reg];
    assign frame_end = fe_reg[ord_ptr_reg];

endmodule

// File: rtl/light_command_frame_builder_core.sv
// ----------------------------------------------------------------------------
// light_command_frame_builder_core
// serializes lighting command frames with a crc-16/modbus trailer
// ----------------------------------------------------------------------------
// Each input word is turned into frame bytes that leave one per cycle on the
// result queue while it has room: a single-channel set gives 11 bytes, a
// status request or error reset 8, and a multi-channel duty element 2 (plus
// the 6-byte header on element 0 and the 2 crc bytes on the last). The byte
// serializer in the back end sets the rate at one byte a clock while the byte
// queue has room, so a stream of middle elements sustains one input word per
// two bytes. A two-entry job queue separates input from serializer and a
// four-entry byte queue separates it from the result side, so either side
// can stall alone. Register 0 (byte 0x0) is frame_channels, register 1
// (byte 0x4) active_channels; write them only while the block is idle.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module light_command_frame_builder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  mode,
    input  logic [7:0]  terminal,
    input  logic [7:0]  channel,
    input  logic [15:0] duty,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        frame_end
);

    logic [4:0]     frame_channels_reg;
    logic [4:0]     active_channels_reg;
    logic           cfg_write;
    logic           job_valid;
    logic           job_take;
    lcfb_pkg::job_t job;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_channels_reg  <= 5'd12;
            active_channels_reg <= 5'd16;
        end
        else if (cfg_write)
        begin
            if (paddr[2])
            begin
                active_channels_reg <= pwdata[4:0];
            end
            else
            begin
                frame_channels_reg <= pwdata[4:0];
            end
        end
    end

    assign prdata = paddr[2] ? {27'd0, active_channels_reg}
                             : {27'd0, frame_channels_reg};

    lcfb_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .mode            (mode),
        .terminal        (terminal),
        .channel         (channel),
        .duty            (duty),
        .frame_channels  (frame_channels_reg),
        .active_channels (active_channels_reg),
        .job_valid       (job_valid),
        .job             (job),
        .job_take        (job_take)
    );

    lcfb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job),
        .job_take  (job_take),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .frame_end (frame_end)
    );

    `ASSERT_ALWAYS(a_take_needs_job, !job_take || job_valid, "job taken from empty queue")
    `ASSERT_ALWAYS(a_job_not_blank, !job_valid || (job.mask != '0), "queued job has no bytes")
    `ASSERT_ALWAYS(a_crc_pair, !job_valid || (job.mask[10] == job.mask[9]), "crc bytes split")
    `ASSERT_NEXT(a_whole_frame_queued, push && !full && (mode != lcfb_pkg::MODE_MULTI), job_valid, "frame word not queued")

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// checks the lighting command frame builder byte for byte against a local
// frame predictor, with random push and pop gaps and live register changes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam logic [2:0] ADDR_FRAME_CHANNELS  = 3'd0;
    localparam logic [2:0] ADDR_ACTIVE_CHANNELS = 3'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  terminal;
        logic [7:0]  channel;
        logic [15:0] duty;
    } cmd_word_t;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } frame_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  mode = lcfb_pkg::MODE_SINGLE;
    logic [7:0]  terminal = '0;
    logic [7:0]  channel = '0;
    logic [15:0] duty = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  out_byte;
    logic        frame_end;

    cmd_word_t   pending_words[$];
    frame_byte_t expected_bytes[$];
    cmd_word_t   cur_word;
    frame_byte_t want;

    // predictor copy of the registers and of the open multi-channel frame
    logic [4:0]  cfg_frame_channels = 5'd12;
    logic [4:0]  cfg_active_channels = 5'd16;
    logic [4:0]  elem_pos = '0;
    logic [15:0] open_crc = lcfb_pkg::CRC_INIT;
    logic [15:0] run_crc = lcfb_pkg::CRC_INIT;

    int push_gap = 0;
    int pop_gap = 0;
    bit no_idle = 1'b0;
    int error_count = 0;

    light_command_frame_builder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .push      (push),
        .full      (full),
        .mode      (mode),
        .terminal  (terminal),
        .channel   (channel),
        .duty      (duty),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .frame_end (frame_end)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // bit-serial form of the reflected crc-16
    function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        r = acc;
        for (int i = 0; i < 8; i++)
        begin
            r = (r >> 1) ^ ((r[0] ^ b[i]) ? lcfb_pkg::CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    function automatic logic [4:0] frame_words(input logic [4:0] n);
        if (n == 5'd0)
        begin
            return 5'd1;
        end
        if (n > 5'(lcfb_pkg::MAX_CHANNELS))
        begin
            return 5'(lcfb_pkg::MAX_CHANNELS);
        end
        return n;
    endfunction

    function automatic void put_byte(input logic [7:0] b);
        expected_bytes.push_back('{value: b, last: 1'b0});
        run_crc = crc16_step(run_crc, b);
    endfunction

    function automatic void put_header(input logic [7:0] term, input logic [7:0] ptype,
                                       input logic [7:0] cmd, input logic [15:0] len);
        put_byte(term);
        put_byte(ptype);
        put_byte(cmd);
        put_byte(lcfb_pkg::HDR_STATUS_OK);
        put_byte(len[15:8]);
        put_byte(len[7:0]);
    endfunction

    function automatic void put_trailer();
        expected_bytes.push_back('{value: run_crc[7:0], last: 1'b0});
        expected_bytes.push_back('{value: run_crc[15:8], last: 1'b1});
    endfunction

    function automatic void predict_frame(input cmd_word_t w);
        logic [4:0]  words;
        logic [15:0] duty_sent;
        words = frame_words(cfg_frame_channels);
        if (w.mode == lcfb_pkg::MODE_MULTI)
        begin
            run_crc = open_crc;
            if (elem_pos == 5'd0)
            begin
                run_crc = lcfb_pkg::CRC_INIT;
                put_header(w.terminal, lcfb_pkg::PT_TRANSMIT, lcfb_pkg::CMD_SET_ALL,
                           16'(8 + 2 * words));
            end
            duty_sent = (elem_pos >= cfg_active_channels) ? 16'h0000 : w.duty;
            put_byte(duty_sent[15:8]);
            put_byte(duty_sent[7:0]);
            // an element at or past the frame size closes the frame
            if (elem_pos + 1 >= words)
            begin
                put_trailer();
                elem_pos = 5'd0;
                open_crc = lcfb_pkg::CRC_INIT;
            end
            else
            begin
                elem_pos = elem_pos + 5'd1;
                open_crc = run_crc;
            end
        end
        else
        begin
            // any other word drops an open multi-channel frame
            elem_pos = 5'd0;
            open_crc = lcfb_pkg::CRC_INIT;
            run_crc = lcfb_pkg::CRC_INIT;
            case (w.mode)
                lcfb_pkg::MODE_SINGLE:
                begin
                    put_header(w.terminal, lcfb_pkg::PT_TRANSMIT, lcfb_pkg::CMD_SET_ONE,
                               {8'h00, lcfb_pkg::LEN_SINGLE});
                    put_byte(w.channel);
                    put_byte(w.duty[15:8]);
                    put_byte(w.duty[7:0]);
                end
                lcfb_pkg::MODE_STATUS:
                begin
                    put_header(w.terminal, lcfb_pkg::PT_REQUEST, lcfb_pkg::CMD_STATUS,
                               {8'h00, lcfb_pkg::LEN_SHORT});
                end
                default:
                begin
                    put_header(w.terminal, lcfb_pkg::PT_TRANSMIT, lcfb_pkg::CMD_ERR_RESET,
                               {8'h00, lcfb_pkg::LEN_SHORT});
                end
            endcase
            put_trailer();
        end
    endfunction

    // input side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            push_gap <= 0;
        end
        else
        begin
            if (push && !full)
            begin
                predict_frame(cur_word);
            end
            if (!push || !full)
            begin
                if (push_gap != 0)
                begin
                    push <= 1'b0;
                    push_gap <= push_gap - 1;
                end
                else if (pending_words.size() != 0)
                begin
                    cur_word = pending_words.pop_front();
                    mode <= cur_word.mode;
                    terminal <= cur_word.terminal;
                    channel <= cur_word.channel;
                    duty <= cur_word.duty;
                    push <= 1'b1;
                    push_gap <= no_idle ? 0 : $urandom_range(0, 3);
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
            pop_gap = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_bytes.size() == 0)
                begin
                    report_mismatch($sformatf("byte %02h arrived with none pending", out_byte));
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (out_byte !== want.value)
                    begin
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  out_byte, want.value));
                    end
                    if (frame_end !== want.last)
                    begin
                        report_mismatch($sformatf("frame_end %b, expected %b on byte %02h",
                                                  frame_end, want.last, want.value));
                    end
                end
                pop_gap = no_idle ? 0 : $urandom_range(0, 3);
            end
            if (pop_gap != 0)
            begin
                pop <= 1'b0;
                pop_gap = pop_gap - 1;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [4:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        // upper bits are junk the register must drop
        pwdata <= ($urandom() & 32'hFFFF_FFE0) | {27'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic reg_check(input logic [2:0] addr, input logic [4:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== {27'd0, value})
        begin
            report_mismatch($sformatf("register at %0d reads %08h, expected %08h",
                                      addr, prdata, {27'd0, value}));
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input logic [4:0] fc, input logic [4:0] ac);
        reg_write(ADDR_FRAME_CHANNELS, fc);
        cfg_frame_channels = fc;
        reg_write(ADDR_ACTIVE_CHANNELS, ac);
        cfg_active_channels = ac;
        reg_check(ADDR_FRAME_CHANNELS, fc);
        reg_check(ADDR_ACTIVE_CHANNELS, ac);
    endtask

    task automatic wait_idle();
        do @(negedge clk);
        while (pending_words.size() != 0 || push || expected_bytes.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    function automatic void queue_word(input logic [1:0] m, input logic [7:0] t,
                                       input logic [7:0] c, input logic [15:0] d);
        pending_words.push_back('{mode: m, terminal: t, channel: c, duty: d});
    endfunction

    function automatic void queue_random(input logic [1:0] m);
        queue_word(m, 8'($urandom()), 8'($urandom()), 16'($urandom()));
    endfunction

    function automatic logic [1:0] standalone_mode();
        case ($urandom_range(0, 2))
            0: return lcfb_pkg::MODE_SINGLE;
            1: return lcfb_pkg::MODE_STATUS;
            default: return lcfb_pkg::MODE_RESET;
        endcase
    endfunction

    task automatic run_random_phase(input logic [4:0] fc, input logic [4:0] ac,
                                    input int target, input bit quiet);
        int queued;
        int pick;
        int n;
        logic [4:0] words;
        set_config(fc, ac);
        no_idle = quiet;
        words = frame_words(fc);
        queued = 0;
        while (queued < target)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
            begin
                for (int i = 0; i < words; i++)
                begin
                    queue_random(lcfb_pkg::MODE_MULTI);
                end
                queued += words;
            end
            else if (pick < 8)
            begin
                queue_random(standalone_mode());
                queued++;
            end
            else if (pick == 8)
            begin
                // up to a full multi-channel frame, then another command that cuts it short
                n = $urandom_range(1, words);
                for (int i = 0; i < n; i++)
                begin
                    queue_random(lcfb_pkg::MODE_MULTI);
                end
                queue_random(standalone_mode());
                queued += n + 1;
            end
            else
            begin
                queue_random(2'($urandom_range(0, 3)));
                queued++;
            end
        end
        wait_idle();
        no_idle = 1'b0;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        reg_check(ADDR_FRAME_CHANNELS, 5'd12);
        reg_check(ADDR_ACTIVE_CHANNELS, 5'd16);

        // field extremes and ignored fields
        queue_word(lcfb_pkg::MODE_SINGLE, 8'h00, 8'h00, 16'h0000);
        queue_word(lcfb_pkg::MODE_SINGLE, 8'hFF, 8'hFF, 16'hFFFF);
        queue_word(lcfb_pkg::MODE_STATUS, 8'hFF, 8'hAA, 16'h1234);
        queue_word(lcfb_pkg::MODE_RESET, 8'h00, 8'h55, 16'hFFFF);
        // open frame dropped by a status request
        queue_word(lcfb_pkg::MODE_MULTI, 8'h3C, 8'h11, 16'hFFFF);
        queue_word(lcfb_pkg::MODE_MULTI, 8'h5A, 8'h22, 16'h0000);
        queue_word(lcfb_pkg::MODE_MULTI, 8'hC3, 8'h33, 16'h8001);
        queue_word(lcfb_pkg::MODE_STATUS, 8'h81, 8'h00, 16'h0000);
        wait_idle();

        // zero frame size acts as one, every duty masked
        set_config(5'd0, 5'd0);
        queue_word(lcfb_pkg::MODE_MULTI, 8'hA5, 8'h00, 16'hFFFF);
        queue_word(lcfb_pkg::MODE_MULTI, 8'h5A, 8'hFF, 16'h7FFF);
        wait_idle();

        // oversize frame, then the size is lowered under the open frame
        set_config(5'd17, 5'd1);
        queue_word(lcfb_pkg::MODE_MULTI, 8'h12, 8'h00, 16'hFFFF);
        queue_word(lcfb_pkg::MODE_MULTI, 8'h34, 8'h00, 16'hFFFF);
        queue_word(lcfb_pkg::MODE_MULTI, 8'h56, 8'h00, 16'h0001);
        wait_idle();
        set_config(5'd2, 5'd16);
        queue_word(lcfb_pkg::MODE_MULTI, 8'h78, 8'h00, 16'hABCD);
        wait_idle();

        run_random_phase(5'd6, 5'd4, 20, 1'b0);
        run_random_phase(5'd10, 5'd10, 20, 1'b1);
        run_random_phase(5'd16, 5'd16, 25, 1'b0);
        run_random_phase(5'd12, 5'd0, 20, 1'b0);
        run_random_phase(5'd31, 5'd31, 20, 1'b0);
        run_random_phase(5'd1, 5'd1, 10, 1'b0);

        repeat (20) @(posedge clk);
        if (error_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/lcfb_pkg.sv
rtl/lcfb_front.sv
rtl/lcfb_back.sv
rtl/light_command_frame_builder_core.sv
verif/testbench.sv
